// ===== sv/b64d_pkg.sv =====
// b64d_pkg: shared types and the character classifier for the base64 decoder
// no dependencies; used by every module of the decoder
package b64d_pkg;

    typedef struct packed {
        logic       ignore;
        logic       pad;
        logic [5:0] sextet;
    } char_class_t;

    // one finished group waiting to be unpacked into bytes
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  last_idx;
        logic        malformed;
    } group_t;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_EQUAL = 8'h3D;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    localparam logic [5:0] SEXTET_LOWER = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
    localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
    localparam logic [1:0] LAST_IDX_THREE = 2'd2;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        logic [7:0]  d;
        r = '{ignore: 1'b0, pad: 1'b0, sextet: 6'd0};
        d = 8'd0;
        if (c inside {[8'h41:8'h5A]})
        begin
            d = c - CHAR_UA;
            r.sextet = d[5:0];
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            d = c - CHAR_LA;
            r.sextet = d[5:0] + SEXTET_LOWER;
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            d = c - CHAR_ZERO;
            r.sextet = d[5:0] + SEXTET_DIGIT;
        end
        else if (c == CHAR_PLUS)
        begin
            r.sextet = SEXTET_PLUS;
        end
        else if (c == CHAR_SLASH)
        begin
            r.sextet = SEXTET_SLASH;
        end
        else if (c == CHAR_EQUAL)
        begin
            r.pad = 1'b1;
        end
        else
        begin
            r.ignore = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== sv/b64d_if.sv =====
// b64d_char_if and b64d_byte_if: valid/ready channels of the base64 decoder
// no dependencies
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_group;
    logic       malformed;

    modport source (output valid, output data_byte, output last_of_group,
                    output malformed, input ready);
    modport sink   (input valid, input data_byte, input last_of_group,
                    input malformed, output ready);
endinterface

// ===== sv/base64_stream_decoder_unit.sv =====
// base64_stream_decoder_unit: streaming base64 decoder, top level
// depends on b64d_pkg, b64d_if, b64d_front, b64d_queue and b64d_back
//
// chars carries one raw character per item; bytes outside the base64
// alphabet and '=' are dropped without a result, so whitespace is harmless.
// each complete group of four characters yields three, two or one decoded
// bytes on octets, the final one with last_of_group set; a group with badly
// placed padding yields a single item with malformed set and data_byte zero.
// a character is taken every cycle while the group queue has room; the
// queue holds four groups and the back part drains one byte per cycle, so
// an unstalled stream runs at one character per cycle.
// a finished group passes a queue slot, the group register and the output
// register in turn; its other bytes follow one per cycle unless stalled.
// when the receiver stalls, the output register holds its item, the queue
// fills and chars.ready falls once it is full.
// reset clears the partial group, the queue and the output register; a
// trailing partial group is never emitted.
module base64_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    b64d_char_if.sink   chars,
    b64d_byte_if.source octets
);

    logic             queue_full;
    logic             push;
    b64d_pkg::group_t push_group;
    logic             pop;
    logic             not_empty;
    b64d_pkg::group_t head;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .queue_full (queue_full),
        .push       (push),
        .push_group (push_group)
    );

    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (not_empty),
        .head       (head)
    );

    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .octets    (octets)
    );

endmodule

// ===== sv/b64d_front.sv =====
// b64d_front: takes characters, gathers sextets and hands finished groups on
// depends on b64d_pkg and b64d_char_if
module b64d_front (
    input  logic                 clk,
    input  logic                 rst_n,
    b64d_char_if.sink            chars,
    input  logic                 queue_full,
    output logic                 push,
    output b64d_pkg::group_t     push_group
);

    logic [1:0]            count_reg, count_next;
    logic [17:0]           acc_reg, acc_next;
    logic                  third_pad_reg, third_pad_next;
    logic                  early_pad_reg, early_pad_next;
    b64d_pkg::char_class_t cls;
    logic                  take;
    logic                  bad;

    assign chars.ready = !queue_full;
    assign cls         = b64d_pkg::classify(chars.char_code);
    assign take        = chars.valid && chars.ready && !cls.ignore;
    assign bad         = early_pad_reg || (third_pad_reg && !cls.pad);

    always_comb
    begin
        count_next     = count_reg;
        acc_next       = acc_reg;
        third_pad_next = third_pad_reg;
        early_pad_next = early_pad_reg;
        push           = 1'b0;
        push_group     = '{bits: {acc_reg, cls.sextet}, last_idx: b64d_pkg::LAST_IDX_THREE,
                           malformed: 1'b0};
        if (take)
        begin
            if (count_reg != 2'd3)
            begin
                if (cls.pad)
                begin
                    if (count_reg[1])
                        third_pad_next = 1'b1;
                    else
                        early_pad_next = 1'b1;
                end
                acc_next   = {acc_reg[11:0], cls.sextet};
                count_next = count_reg + 2'd1;
            end
            else
            begin
                push = 1'b1;
                if (bad)
                begin
                    push_group.bits      = 24'd0;
                    push_group.last_idx  = b64d_pkg::LAST_IDX_ONE;
                    push_group.malformed = 1'b1;
                end
                else if (third_pad_reg)
                    push_group.last_idx = b64d_pkg::LAST_IDX_ONE;
                else if (cls.pad)
                    push_group.last_idx = b64d_pkg::LAST_IDX_TWO;
                count_next     = 2'd0;
                acc_next       = 18'd0;
                third_pad_next = 1'b0;
                early_pad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 2'd0;
            acc_reg       <= 18'd0;
            third_pad_reg <= 1'b0;
            early_pad_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            third_pad_reg <= third_pad_next;
            early_pad_reg <= early_pad_next;
        end
    end

endmodule

// ===== sv/b64d_queue.sv =====
// b64d_queue: short group queue between the front and back parts
// depends on b64d_pkg
module b64d_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64d_pkg::group_t push_group,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output b64d_pkg::group_t head
);

    localparam int unsigned PW = b64d_pkg::QPTR_W;

    b64d_pkg::group_t  slots_reg [b64d_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full      = (fill_reg == (PW+1)'(b64d_pkg::QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(do_push);
        rd_ptr_next = rd_ptr_reg + PW'(do_pop);
        fill_next   = fill_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== sv/b64d_back.sv =====
// b64d_back: unpacks queued groups into bytes through an output register
// depends on b64d_pkg and b64d_byte_if
module b64d_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             not_empty,
    input  b64d_pkg::group_t head,
    output logic             pop,
    b64d_byte_if.source      octets
);

    b64d_pkg::group_t grp_reg, grp_next;
    logic             grp_valid_reg, grp_valid_next;
    logic [1:0]       idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic             out_bad_reg, out_bad_next;
    logic             emit;
    logic             at_last;
    logic [7:0]       sel_byte;

    assign emit    = grp_valid_reg && (!out_valid_reg || octets.ready);
    assign at_last = (idx_reg == grp_reg.last_idx);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = grp_reg.bits[23:16];
            2'd1:    sel_byte = grp_reg.bits[15:8];
            default: sel_byte = grp_reg.bits[7:0];
        endcase
    end

    // refill the group stage when it is empty or its last byte leaves now
    assign pop = not_empty && (!grp_valid_reg || (emit && at_last));

    always_comb
    begin
        grp_next       = grp_reg;
        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        if (out_valid_reg && octets.ready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sel_byte;
            out_last_next  = at_last;
            out_bad_next   = grp_reg.malformed;
            idx_next       = idx_reg + 2'd1;
            if (at_last)
                grp_valid_next = 1'b0;
        end
        if (pop)
        begin
            grp_next       = head;
            grp_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg      <= grp_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            grp_valid_reg <= grp_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign octets.valid         = out_valid_reg;
    assign octets.data_byte     = out_data_reg;
    assign octets.last_of_group = out_last_reg;
    assign octets.malformed     = out_bad_reg;

endmodule
